// ----- hdl/heron_pkg.sv -----
// Shared types and constants for the Heron square root iteration block.
package heron_pkg;

    // Fixed field widths of the register file and the stream words.
    localparam int RADICAND_WIDTH  = 31;
    localparam int TOLERANCE_WIDTH = 21;
    localparam int ITER_WIDTH      = 10;
    localparam int STATUS_WIDTH    = 2;
    localparam int ROOT_WIDTH      = 32;
    localparam int GUESS_WIDTH     = 32;
    localparam int CFG_DATA_WIDTH  = 31;
    localparam int CFG_ADDR_WIDTH  = 2;
    localparam int IN_WORD_WIDTH   = 32;
    localparam int OUT_WORD_WIDTH  = 48;

    // Result status codes.
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_ZERO_DIV  = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_RADICAND  = 2'd0,
        REG_TOLERANCE = 2'd1,
        REG_MAX_ITER  = 2'd2
    } cfg_index_t;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIVIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_EMIT   = 5'b10000
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_guess;
        logic    div_start;
        logic    div_step;
        logic    update;
        logic    emit;
        status_t status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_limit;
        logic est_zero;
        logic div_last;
        logic converged;
        logic out_free;
    } sts_t;

endpackage

// ----- hdl/heron_square_root_iteration_top.sv -----
// Top level of the Heron square root iteration block.
// Each input word is a starting guess; the block repeats x = (x + radicand / x) / 2
// until two successive estimates differ by less than the tolerance, the iteration
// limit is reached, or the estimate becomes zero, and then returns one result word.
// An iteration runs the one-bit-per-cycle restoring divider over RADICAND_WIDTH plus
// FRACTION_BITS dividend bits, then the update and the checks; the default format is
// Q12.20. One item is worked on at a time; the next guess is taken as soon as the
// result sits in the output register.
// Configuration registers are to be written through the plain write port only while
// idle; the block itself does not enforce this.
module heron_square_root_iteration_top #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_wen,
    input  logic [heron_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [heron_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    // Input stream.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [heron_pkg::IN_WORD_WIDTH-1:0]   s_axis_tdata,  // [31:0] initial_guess
    // Output stream.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [heron_pkg::OUT_WORD_WIDTH-1:0]  m_axis_tdata   // [31:0] root,
                                                                 // [41:32] iterations,
                                                                 // [43:42] status
);

    localparam logic [heron_pkg::RADICAND_WIDTH-1:0] RADICAND_RESET =
        heron_pkg::RADICAND_WIDTH'(64'd5 << FRACTION_BITS);

    logic [heron_pkg::RADICAND_WIDTH-1:0]  radicand_reg;
    logic [heron_pkg::TOLERANCE_WIDTH-1:0] tolerance_reg;
    logic [heron_pkg::ITER_WIDTH-1:0]      max_iter_reg;
    heron_pkg::cmd_t                       cmd;
    heron_pkg::sts_t                       sts;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radicand_reg  <= RADICAND_RESET;
            tolerance_reg <= heron_pkg::TOLERANCE_WIDTH'(2);
            max_iter_reg  <= heron_pkg::ITER_WIDTH'(100);
        end
        else if (cfg_wen)
        begin
            unique case (heron_pkg::cfg_index_t'(cfg_addr))
                heron_pkg::REG_RADICAND:
                begin
                    radicand_reg <= cfg_wdata[heron_pkg::RADICAND_WIDTH-1:0];
                end
                heron_pkg::REG_TOLERANCE:
                begin
                    tolerance_reg <= cfg_wdata[heron_pkg::TOLERANCE_WIDTH-1:0];
                end
                heron_pkg::REG_MAX_ITER:
                begin
                    max_iter_reg <= cfg_wdata[heron_pkg::ITER_WIDTH-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    heron_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    heron_dp #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .initial_guess  ($signed(s_axis_tdata[heron_pkg::GUESS_WIDTH-1:0])),
        .radicand       (radicand_reg),
        .tolerance      (tolerance_reg),
        .max_iterations (max_iter_reg),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

// ----- hdl/heron_ctrl.sv -----
// Sequencing controller for the Heron square root iteration.
module heron_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  heron_pkg::sts_t      sts,
    output heron_pkg::cmd_t      cmd
);

    heron_pkg::fsm_state_t state_reg, state_next;
    heron_pkg::status_t    status_reg, status_next;

    // A new word is taken only when no item is in progress.
    assign s_axis_tready = (state_reg == heron_pkg::S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        unique case (state_reg)
            heron_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load_guess = 1'b1;
                    state_next     = heron_pkg::S_CHECK;
                end
            end
            heron_pkg::S_CHECK:
            begin
                // The limit is tested before the zero estimate.
                if (sts.at_limit)
                begin
                    status_next = heron_pkg::ST_LIMIT;
                    state_next  = heron_pkg::S_EMIT;
                end
                else if (sts.est_zero)
                begin
                    status_next = heron_pkg::ST_ZERO_DIV;
                    state_next  = heron_pkg::S_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = heron_pkg::S_DIVIDE;
                end
            end
            heron_pkg::S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = heron_pkg::S_UPDATE;
                end
            end
            heron_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (sts.converged)
                begin
                    status_next = heron_pkg::ST_CONVERGED;
                    state_next  = heron_pkg::S_EMIT;
                end
                else
                begin
                    state_next = heron_pkg::S_CHECK;
                end
            end
            heron_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = heron_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = heron_pkg::S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= heron_pkg::S_IDLE;
            status_reg <= heron_pkg::ST_CONVERGED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- hdl/heron_dp.sv -----
// Datapath: estimate register, serial divider, averaging step and output register.
module heron_dp #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 20
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  heron_pkg::cmd_t                        cmd,
    output heron_pkg::sts_t                        sts,
    input  logic signed [heron_pkg::GUESS_WIDTH-1:0]   initial_guess,
    input  logic [heron_pkg::RADICAND_WIDTH-1:0]   radicand,
    input  logic [heron_pkg::TOLERANCE_WIDTH-1:0]  tolerance,
    input  logic [heron_pkg::ITER_WIDTH-1:0]       max_iterations,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [heron_pkg::OUT_WORD_WIDTH-1:0]   m_axis_tdata
);

    localparam int W     = VALUE_WIDTH;
    localparam int N     = heron_pkg::RADICAND_WIDTH + FRACTION_BITS;
    localparam int CNT_W = $clog2(N);
    localparam int GW    = (W > heron_pkg::GUESS_WIDTH) ? W : heron_pkg::GUESS_WIDTH;
    localparam int RW    = (W > heron_pkg::ROOT_WIDTH) ? W : heron_pkg::ROOT_WIDTH;
    localparam int CW    = (W + 1 > heron_pkg::TOLERANCE_WIDTH) ? W + 1
                                                                 : heron_pkg::TOLERANCE_WIDTH;
    localparam int PAD_W = heron_pkg::OUT_WORD_WIDTH - heron_pkg::ROOT_WIDTH
                           - heron_pkg::ITER_WIDTH - heron_pkg::STATUS_WIDTH;

    logic signed [W-1:0]                   est_reg, est_next;
    logic [heron_pkg::ITER_WIDTH-1:0]      step_reg, step_next;
    logic [N-1:0]                          divd_reg, divd_next;
    logic [W-1:0]                          rem_reg, rem_next;
    logic [W-2:0]                          quo_reg, quo_next;
    logic                                  over_reg, over_next;
    logic [W-1:0]                          dvs_reg, dvs_next;
    logic                                  neg_reg, neg_next;
    logic [CNT_W-1:0]                      cnt_reg, cnt_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [heron_pkg::ROOT_WIDTH-1:0]      out_root_reg, out_root_next;
    logic [heron_pkg::ITER_WIDTH-1:0]      out_iters_reg, out_iters_next;
    heron_pkg::status_t                    out_status_reg, out_status_next;

    logic signed [GW-1:0]                  guess_ext, guess_hi, guess_lo;
    logic signed [W-1:0]                   guess_sat;
    logic [W:0]                            rem_shift, rem_sub;
    logic                                  qbit, over_hit;
    logic [W-2:0]                          quo_mag;
    logic [W-1:0]                          quo_signed;
    logic [W:0]                            avg_sum, delta, diff_mag;
    logic signed [W-1:0]                   avg;
    logic signed [RW-1:0]                  root_ext, root_hi, root_lo;
    logic [heron_pkg::ROOT_WIDTH-1:0]      root_sat;

    // Saturate the incoming guess into the value range.
    assign guess_ext = GW'(initial_guess);
    assign guess_hi  = $signed({{(GW - W + 1){1'b0}}, {(W - 1){1'b1}}});
    assign guess_lo  = $signed({{(GW - W + 1){1'b1}}, {(W - 1){1'b0}}});
    assign guess_sat = (guess_ext > guess_hi) ? guess_hi[W-1:0] :
                       (guess_ext < guess_lo) ? guess_lo[W-1:0] : guess_ext[W-1:0];

    // One restoring division step per cycle on the magnitude.
    assign rem_shift = {rem_reg, divd_reg[N-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign qbit      = (rem_shift >= {1'b0, dvs_reg});
    assign over_hit  = quo_reg[W-2];

    // Signed, saturated quotient and the floor average with the estimate.
    assign quo_mag    = over_reg ? '1 : quo_reg;
    assign quo_signed = neg_reg ? (W'(0) - {1'b0, quo_mag}) : {1'b0, quo_mag};
    assign avg_sum    = {est_reg[W-1], est_reg} + {quo_signed[W-1], quo_signed};
    assign avg        = avg_sum[W:1];
    assign delta      = {avg[W-1], avg} - {est_reg[W-1], est_reg};
    assign diff_mag   = delta[W] ? ((W + 1)'(0) - delta) : delta;

    // Saturate the final estimate into the result field.
    assign root_ext = RW'(est_reg);
    assign root_hi  = $signed({{(RW - 31){1'b0}}, {31{1'b1}}});
    assign root_lo  = $signed({{(RW - 31){1'b1}}, {31{1'b0}}});
    assign root_sat = (root_ext > root_hi) ? root_hi[heron_pkg::ROOT_WIDTH-1:0] :
                      (root_ext < root_lo) ? root_lo[heron_pkg::ROOT_WIDTH-1:0] :
                      root_ext[heron_pkg::ROOT_WIDTH-1:0];

    // Status toward the controller.
    assign sts.at_limit  = (step_reg == max_iterations);
    assign sts.est_zero  = (est_reg == '0);
    assign sts.div_last  = (cnt_reg == '0);
    assign sts.converged = (CW'(diff_mag) < CW'(tolerance));
    assign sts.out_free  = !out_valid_reg || m_axis_tready;

    // Next values of the working registers.
    always_comb
    begin
        est_next        = est_reg;
        step_next       = step_reg;
        divd_next       = divd_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        over_next       = over_reg;
        dvs_next        = dvs_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_root_next   = out_root_reg;
        out_iters_next  = out_iters_reg;
        out_status_next = out_status_reg;

        if (cmd.load_guess)
        begin
            est_next  = guess_sat;
            step_next = '0;
        end

        if (cmd.div_start)
        begin
            divd_next = {radicand, {FRACTION_BITS{1'b0}}};
            rem_next  = '0;
            quo_next  = '0;
            over_next = 1'b0;
            neg_next  = est_reg[W-1];
            dvs_next  = est_reg[W-1] ? (W'(0) - est_reg) : est_reg;
            cnt_next  = CNT_W'(N - 1);
        end

        if (cmd.div_step)
        begin
            divd_next = {divd_reg[N-2:0], 1'b0};
            rem_next  = qbit ? rem_sub[W-1:0] : rem_shift[W-1:0];
            over_next = over_reg || over_hit;
            if (!(over_reg || over_hit))
            begin
                quo_next = {quo_reg[W-3:0], qbit};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
        end

        // The new estimate and count are kept also on the converging step.
        if (cmd.update)
        begin
            est_next  = avg;
            step_next = step_reg + heron_pkg::ITER_WIDTH'(1);
        end

        // Output register: load a result or drop the word once taken.
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_root_next   = root_sat;
            out_iters_next  = step_reg;
            out_status_next = cmd.status;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        est_reg        <= est_next;
        step_reg       <= step_next;
        divd_reg       <= divd_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        over_reg       <= over_next;
        dvs_reg        <= dvs_next;
        neg_reg        <= neg_next;
        cnt_reg        <= cnt_next;
        out_root_reg   <= out_root_next;
        out_iters_reg  <= out_iters_next;
        out_status_reg <= out_status_next;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_status_reg, out_iters_reg, out_root_reg};

endmodule

// ----- hdl/heron_chk.sv -----
// Port-level checker for the Heron square root iteration block, with its bind.
module heron_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [heron_pkg::OUT_WORD_WIDTH-1:0]  m_axis_tdata
);

    // After taking a guess the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item was just started");

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    // A converged result counts the converging iteration.
    a_conv_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[43:42] == heron_pkg::ST_CONVERGED))
        |-> (m_axis_tdata[41:32] != '0))
        else $error("converged result with zero iterations");

    // A zero estimate result carries a zero root.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[43:42] == heron_pkg::ST_ZERO_DIV))
        |-> (m_axis_tdata[31:0] == '0))
        else $error("zero estimate result with nonzero root");

    // Only the defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[43:42] == heron_pkg::ST_CONVERGED ||
                           m_axis_tdata[43:42] == heron_pkg::ST_LIMIT ||
                           m_axis_tdata[43:42] == heron_pkg::ST_ZERO_DIV))
        else $error("undefined status code in result");

endmodule

bind heron_square_root_iteration_top heron_chk u_heron_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
